// ===== sv/awq_pkg.sv =====
`timescale 1ns / 1ps
package awq_pkg;
    localparam int LANES = 8;
    localparam logic [31:0] QNAN_DEFAULT = 32'h7FC0_0000;
    localparam logic [31:0] QUIET_BIT = 32'h0040_0000;

    // bit offset of each lane's nibble in the packed words
    function automatic logic [4:0] lane_shift(input logic [2:0] lane);
        logic [4:0] sh;
        begin
            case (lane)
                3'd0: sh = 5'd0;
                3'd1: sh = 5'd16;
                3'd2: sh = 5'd4;
                3'd3: sh = 5'd20;
                3'd4: sh = 5'd8;
                3'd5: sh = 5'd24;
                3'd6: sh = 5'd12;
                3'd7: sh = 5'd28;
                default: sh = 5'd0;
            endcase
            return sh;
        end
    endfunction

    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        zero;
        logic        inf;
        logic        sign;
        logic signed [10:0] expo;
        logic [27:0] prod;
    } awq_mid_t;
endpackage

// ===== sv/awq_int4_dequantizer.sv =====
`timescale 1ns / 1ps
// Throughput: one request per cycle while the output is not stalled;
// three register stages per lane (multiply, normalize, round), all
// eight lanes in parallel.
// A stall on the output freezes the whole pipeline.
// Reset clears the stage valid bits only.
module awq_int4_dequantizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] weight_word,
    input  logic [31:0] zero_word,
    input  logic [31:0] scale_0,
    input  logic [31:0] scale_1,
    input  logic [31:0] scale_2,
    input  logic [31:0] scale_3,
    input  logic [31:0] scale_4,
    input  logic [31:0] scale_5,
    input  logic [31:0] scale_6,
    input  logic [31:0] scale_7,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] value_0,
    output logic [31:0] value_1,
    output logic [31:0] value_2,
    output logic [31:0] value_3,
    output logic [31:0] value_4,
    output logic [31:0] value_5,
    output logic [31:0] value_6,
    output logic [31:0] value_7
);
    logic [2:0] vld_reg, vld_next;
    logic       en;
    logic [31:0] scales [awq_pkg::LANES];
    logic [31:0] vals [awq_pkg::LANES];

    // advance only when the output stage is free
    assign en = !(vld_reg[2] && out_stall);
    assign in_stall = !en;
    assign out_valid = vld_reg[2];
    assign vld_next = {vld_reg[1:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 3'd0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    assign scales[0] = scale_0;
    assign scales[1] = scale_1;
    assign scales[2] = scale_2;
    assign scales[3] = scale_3;
    assign scales[4] = scale_4;
    assign scales[5] = scale_5;
    assign scales[6] = scale_6;
    assign scales[7] = scale_7;

    for (genvar g = 0; g < awq_pkg::LANES; g++)
    begin : g_lane
        localparam logic [4:0] SH = awq_pkg::lane_shift(3'(g));
        awq_lane u_lane
        (
            .clk   (clk),
            .en    (en),
            .w     (weight_word[SH +: 4]),
            .z     (zero_word[SH +: 4]),
            .scale (scales[g]),
            .value (vals[g])
        );
    end

    assign value_0 = vals[0];
    assign value_1 = vals[1];
    assign value_2 = vals[2];
    assign value_3 = vals[3];
    assign value_4 = vals[4];
    assign value_5 = vals[5];
    assign value_6 = vals[6];
    assign value_7 = vals[7];
endmodule

// ===== sv/awq_lane.sv =====
`timescale 1ns / 1ps
// One lane: stage 1 decodes and multiplies, stage 2 normalizes, stage 3 rounds.
module awq_lane
(
    input  logic        clk,
    input  logic        en,
    input  logic [3:0]  w,
    input  logic [3:0]  z,
    input  logic [31:0] scale,
    output logic [31:0] value
);
    logic signed [4:0] diff;
    logic [3:0]  mag;
    logic [7:0]  sexp;
    logic [22:0] sman;
    logic [23:0] sig;
    awq_pkg::awq_mid_t s1_next, s1_reg;

    assign diff = $signed({1'b0, w}) - $signed({1'b0, z});
    assign mag  = diff[4] ? 4'(-diff) : diff[3:0];
    assign sexp = scale[30:23];
    assign sman = scale[22:0];
    assign sig  = {(sexp != 8'd0), sman};

    always_comb
    begin
        s1_next.special = 1'b0;
        s1_next.special_val = scale | awq_pkg::QUIET_BIT;
        if (sexp == 8'hFF && sman != 23'd0)
        begin
            s1_next.special = 1'b1;
        end
        else if (sexp == 8'hFF && mag == 4'd0)
        begin
            s1_next.special = 1'b1;
            s1_next.special_val = awq_pkg::QNAN_DEFAULT;
        end
        s1_next.sign = diff[4] ^ scale[31];
        s1_next.inf  = (sexp == 8'hFF);
        s1_next.zero = (mag == 4'd0) || (sexp == 8'd0 && sman == 23'd0);
        // value = prod * 2^(expo - 150), prod has up to 28 bits
        s1_next.expo = (sexp == 8'd0) ? 11'sd1 : $signed({3'b0, sexp});
        s1_next.prod = 28'(sig) * 28'(mag);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
        end
    end

    // stage 2: normalize so bit 27 is the leading one
    logic [4:0]  lz;
    logic [27:0] norm;
    logic signed [11:0] e2;
    awq_pkg::awq_mid_t s2_next, s2_reg;

    always_comb
    begin
        lz = 5'd0;
        for (int i = 0; i < 28; i++)
        begin
            if (s1_reg.prod[i])
            begin
                lz = 5'(27 - i);
            end
        end
        norm = s1_reg.prod << lz;
        // value = norm * 2^(e2 - 27 - 127), biased exponent of 1.f is e2
        e2 = 12'(s1_reg.expo) + 12'sd4 - 12'($signed({1'b0, lz}));
        s2_next = s1_reg;
        s2_next.prod = norm;
        s2_next.expo = 11'(e2);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
        end
    end

    // stage 3: denormalize if needed, round to nearest even, pack
    logic [5:0]  rsh;
    logic [55:0] wide;
    logic [24:0] kept;
    logic        rbit;
    logic        sticky;
    logic [24:0] rnd;
    logic signed [11:0] ef;
    logic [31:0] val_next, val_reg;

    always_comb
    begin
        rsh = 6'd0;
        if (s2_reg.expo < 11'sd1)
        begin
            rsh = (s2_reg.expo < -11'sd26) ? 6'd27 : 6'(11'sd1 - s2_reg.expo);
        end
        wide = {s2_reg.prod, 28'd0} >> rsh;
        kept = {1'b0, wide[55:32]};
        rbit = wide[31];
        sticky = |wide[30:0];
        rnd = kept + 25'(rbit & (sticky | kept[0]));
        ef = (s2_reg.expo < 11'sd1) ? 12'sd0 : 12'(s2_reg.expo);
        if (rnd[24])
        begin
            ef = ef + 12'sd1;
        end
        else if (ef == 12'sd0 && rnd[23])
        begin
            ef = 12'sd1;
        end
        if (s2_reg.special)
        begin
            val_next = s2_reg.special_val;
        end
        else if (s2_reg.zero)
        begin
            val_next = {s2_reg.sign, 31'd0};
        end
        else if (s2_reg.inf || ef >= 12'sd255)
        begin
            val_next = {s2_reg.sign, 8'hFF, 23'd0};
        end
        else
        begin
            val_next = {s2_reg.sign, ef[7:0], rnd[24] ? rnd[23:1] : rnd[22:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= val_next;
        end
    end

    assign value = val_reg;
endmodule
